// ===== design/polyline_wide_line_quad_expander_defines.svh =====
// assertion macros for the wide line quad expander
`ifndef POLYLINE_WIDE_LINE_QUAD_EXPANDER_DEFINES_SVH
`define POLYLINE_WIDE_LINE_QUAD_EXPANDER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PWLQ_ASSERT_IMP(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define PWLQ_ASSERT_NXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define PWLQ_ASSERT_IMP(name, clk, rst, pre, post, msg)
`define PWLQ_ASSERT_NXT(name, clk, rst, pre, post, msg)
`endif

`endif

// ===== design/pwlq_pkg.sv =====
// shared types and constants of the wide line quad expander
package pwlq_pkg;

  localparam int H_W       = 20;
  localparam int OFF_W     = 20;
  localparam int DIV_STEPS = 21;

  localparam logic [1:0] CLASS_HIGHWAY   = 2'd0;
  localparam logic [1:0] CLASS_BOULEVARD = 2'd1;
  localparam logic [1:0] CLASS_AVENUE    = 2'd2;
  localparam logic [1:0] CLASS_STREET    = 2'd3;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  localparam logic [2:0] VTX_LAST = 3'd5;

  typedef struct packed {
    logic               start_line;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         road_class;
    logic [15:0]        base_width;
    logic signed [15:0] layer_height;
    logic [31:0]        color_rgba;
  } point_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [15:0] vert_z;
    logic [31:0]        vert_color;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic [H_W-1:0]     h;
  } calc_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] mox;
    logic [OFF_W-1:0] moy;
    logic             neg_x;
    logic             neg_y;
  } calc_rsp_t;

  typedef struct packed {
    logic        op;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] ma;
    logic [31:0] mb;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] res;
    logic        ge;
    logic [63:0] prod;
  } alu_rsp_t;

endpackage

// ===== design/pwlq_channels_if.sv =====
// valid/ready channel interfaces for points and vertices
interface pwlq_point_if ();
  logic              valid;
  logic              ready;
  pwlq_pkg::point_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwlq_vertex_if ();
  logic              valid;
  logic              ready;
  pwlq_pkg::vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/pwlq_alu.sv =====
// shared add/subtract-compare and multiply unit
module pwlq_alu (
  input  pwlq_pkg::alu_req_t req,
  output pwlq_pkg::alu_rsp_t rsp
);

  logic        sub;
  logic [63:0] b_eff;
  logic [64:0] wide;

  assign sub   = (req.op == pwlq_pkg::ALU_SUB);
  assign b_eff = sub ? ~req.b : req.b;
  assign wide  = {1'b0, req.a} + {1'b0, b_eff} + {64'd0, sub};

  // carry out of a - b means a >= b
  assign rsp.res  = wide[63:0];
  assign rsp.ge   = wide[64];
  assign rsp.prod = {32'd0, req.ma} * {32'd0, req.mb};

endmodule

// ===== design/pwlq_seq.sv =====
// sequencer for the segment offset: deltas, scaling, square root, divisions
module pwlq_seq (
  input  logic                clk,
  input  logic                rst,
  input  pwlq_pkg::calc_req_t req,
  output pwlq_pkg::calc_rsp_t rsp,
  output pwlq_pkg::alu_req_t  alu_req,
  input  pwlq_pkg::alu_rsp_t  alu_rsp
);

  localparam int DS  = pwlq_pkg::DIV_STEPS;
  localparam int CNT_W = $clog2(DS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DX   = 4'd1;
  localparam logic [3:0] S_DY   = 4'd2;
  localparam logic [3:0] S_ABS  = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_SQX  = 4'd5;
  localparam logic [3:0] S_SQY  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_ROOT = 4'd8;
  localparam logic [3:0] S_MULX = 4'd9;
  localparam logic [3:0] S_ADDX = 4'd10;
  localparam logic [3:0] S_DIVX = 4'd11;
  localparam logic [3:0] S_MULY = 4'd12;
  localparam logic [3:0] S_ADDY = 4'd13;
  localparam logic [3:0] S_DIVY = 4'd14;

  logic [3:0]                  state;
  logic                        done;
  logic signed [32:0]          dx;
  logic signed [32:0]          dy;
  logic [31:0]                 ax;
  logic [31:0]                 ay;
  logic [63:0]                 t0;
  logic [63:0]                 t1;
  logic [63:0]                 s;
  logic [63:0]                 res;
  logic [63:0]                 bitm;
  logic [31:0]                 rem;
  logic [DS-1:0]               qd;
  logic [CNT_W-1:0]            cnt;
  logic [pwlq_pkg::OFF_W-1:0]  mox;
  logic [pwlq_pkg::OFF_W-1:0]  moy;

  logic [31:0]                 mx;
  logic [32:0]                 neg_dx;
  logic [32:0]                 neg_dy;
  logic [DS-1:0]               qd_shift;
  logic                        div_last;

  assign mx       = (ax > ay) ? ax : ay;
  assign neg_dx   = -dx;
  assign neg_dy   = -dy;
  assign qd_shift = {qd[DS-2:0], alu_rsp.ge};
  assign div_last = (cnt == CNT_W'(DS - 1));

  assign rsp.done  = done;
  assign rsp.mox   = mox;
  assign rsp.moy   = moy;
  assign rsp.neg_x = !dy[32] && (dy != 33'sd0);
  assign rsp.neg_y = dx[32];

  // operand steering into the shared unit
  always_comb begin
    alu_req.op = pwlq_pkg::ALU_ADD;
    alu_req.a  = 64'd0;
    alu_req.b  = 64'd0;
    alu_req.ma = 32'd0;
    alu_req.mb = 32'd0;
    unique case (state)
      S_DX: begin
        alu_req.op = pwlq_pkg::ALU_SUB;
        alu_req.a  = {{32{req.cur_x[31]}}, req.cur_x};
        alu_req.b  = {{32{req.prev_x[31]}}, req.prev_x};
      end
      S_DY: begin
        alu_req.op = pwlq_pkg::ALU_SUB;
        alu_req.a  = {{32{req.cur_y[31]}}, req.cur_y};
        alu_req.b  = {{32{req.prev_y[31]}}, req.prev_y};
      end
      S_SQX: begin
        alu_req.ma = ax;
        alu_req.mb = ax;
      end
      S_SQY: begin
        alu_req.ma = ay;
        alu_req.mb = ay;
      end
      S_SUM: begin
        alu_req.a = t0;
        alu_req.b = t1;
      end
      S_ROOT: begin
        alu_req.op = pwlq_pkg::ALU_SUB;
        alu_req.a  = s;
        alu_req.b  = res | bitm;
      end
      S_MULX: begin
        alu_req.ma = ay;
        alu_req.mb = {{(32 - pwlq_pkg::H_W){1'b0}}, req.h};
      end
      S_MULY: begin
        alu_req.ma = ax;
        alu_req.mb = {{(32 - pwlq_pkg::H_W){1'b0}}, req.h};
      end
      S_ADDX, S_ADDY: begin
        alu_req.a = t0;
        alu_req.b = {33'd0, res[31:1]};
      end
      S_DIVX, S_DIVY: begin
        alu_req.op = pwlq_pkg::ALU_SUB;
        alu_req.a  = {31'd0, rem, qd[DS-1]};
        alu_req.b  = {32'd0, res[31:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) state <= S_DX;
        end
        S_DX: begin
          dx    <= alu_rsp.res[32:0];
          state <= S_DY;
        end
        S_DY: begin
          dy    <= alu_rsp.res[32:0];
          state <= S_ABS;
        end
        S_ABS: begin
          ax <= dx[32] ? neg_dx[31:0] : dx[31:0];
          ay <= dy[32] ? neg_dy[31:0] : dy[31:0];
          if (dx == 33'sd0 && dy == 33'sd0) begin
            // zero-length segment: no offset
            mox   <= '0;
            moy   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the larger magnitude into [2^30, 2^31)
          if (mx[31]) begin
            ax    <= ax >> 1;
            ay    <= ay >> 1;
            state <= S_SQX;
          end else if (mx[30]) begin
            state <= S_SQX;
          end else if (mx[30:15] == 16'd0) begin
            ax <= ax << 16;
            ay <= ay << 16;
          end else if (mx[30:23] == 8'd0) begin
            ax <= ax << 8;
            ay <= ay << 8;
          end else if (mx[30:27] == 4'd0) begin
            ax <= ax << 4;
            ay <= ay << 4;
          end else if (mx[30:29] == 2'd0) begin
            ax <= ax << 2;
            ay <= ay << 2;
          end else begin
            ax <= ax << 1;
            ay <= ay << 1;
          end
        end
        S_SQX: begin
          t0    <= alu_rsp.prod;
          state <= S_SQY;
        end
        S_SQY: begin
          t1    <= alu_rsp.prod;
          state <= S_SUM;
        end
        S_SUM: begin
          s     <= alu_rsp.res;
          res   <= 64'd0;
          bitm  <= (alu_rsp.res[63:62] != 2'd0) ? (64'd1 << 62) : (64'd1 << 60);
          state <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle, res and bitm never overlap
          if (alu_rsp.ge) begin
            s   <= alu_rsp.res;
            res <= (res >> 1) | bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0]) state <= S_MULX;
        end
        S_MULX, S_MULY: begin
          t0    <= alu_rsp.prod;
          state <= (state == S_MULX) ? S_ADDX : S_ADDY;
        end
        S_ADDX, S_ADDY: begin
          // quotient fits in DS bits, so the upper part starts below len
          rem   <= alu_rsp.res[DS+31:DS];
          qd    <= alu_rsp.res[DS-1:0];
          cnt   <= '0;
          state <= (state == S_ADDX) ? S_DIVX : S_DIVY;
        end
        S_DIVX, S_DIVY: begin
          rem <= alu_rsp.ge ? alu_rsp.res[31:0] : {rem[30:0], qd[DS-1]};
          qd  <= qd_shift;
          cnt <= cnt + 1'b1;
          if (div_last) begin
            if (state == S_DIVX) begin
              mox   <= qd_shift[pwlq_pkg::OFF_W-1:0];
              state <= S_MULY;
            end else begin
              moy   <= qd_shift[pwlq_pkg::OFF_W-1:0];
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/polyline_wide_line_quad_expander.sv =====
// top level of the wide polyline to triangle pair expander
//
// channels: pt takes polyline points (valid/ready), vtx gives vertices
// (valid/ready). a beat moves on a clock edge with valid and ready high.
// a point with start_line set, or any point with no predecessor, is stored
// and gives no vertices. every other point closes a segment
// and gives six vertex beats, two triangles p0,p1,p2 and p0,p2,p3, the
// sixth marked with last_vertex.
// the shared unit walks the deltas, scaling (1 to 5 steps), the squares,
// the bit-serial square root (31 or 32 steps) and, per axis, a multiply,
// a rounding add and a 21-step restoring division. a zero-length segment
// skips everything from the scaling on and gives zero offsets.
// pt.ready is high only while no segment is in flight: a new point is not
// taken before the last vertex of the current segment is loaded.
// reset (rst, synchronous) forgets the previous point and drops any
// pending vertex. a stalled receiver holds the vertex register; the next
// point is taken while the last vertex of a segment still waits.
`include "polyline_wide_line_quad_expander_defines.svh"

module polyline_wide_line_quad_expander (
  input  logic                 clk,
  input  logic                 rst,
  pwlq_point_if.sink           pt,
  pwlq_vertex_if.source        vtx
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_CALC = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0]                 state;
  logic                       have_prev;
  logic                       go;
  logic signed [31:0]         prev_x;
  logic signed [31:0]         prev_y;
  logic signed [31:0]         cur_x;
  logic signed [31:0]         cur_y;
  logic [pwlq_pkg::H_W-1:0]   h;
  logic signed [15:0]         z;
  logic [31:0]                color;
  logic [2:0]                 vcnt;
  logic                       out_vld;
  pwlq_pkg::vertex_t          out_data;

  pwlq_pkg::calc_req_t        calc_req;
  pwlq_pkg::calc_rsp_t        calc_rsp;
  pwlq_pkg::alu_req_t         alu_req;
  pwlq_pkg::alu_rsp_t         alu_rsp;

  logic                       accept;
  logic                       open_line;
  logic [pwlq_pkg::H_W-1:0]   bw_ext;
  logic [pwlq_pkg::H_W-1:0]   h_next;
  logic                       load;
  logic                       sel_cur;
  logic                       plus;
  pwlq_pkg::vertex_t          vert_next;

  // base +/- offset, clamped to the signed 32-bit range
  function automatic logic [31:0] offset_sat(input logic [31:0] base,
                                             input logic [pwlq_pkg::OFF_W-1:0] mag,
                                             input logic add);
    logic [33:0] wide;
    logic [33:0] ext;
    wide = {{2{base[31]}}, base};
    ext  = {{(34 - pwlq_pkg::OFF_W){1'b0}}, mag};
    wide = add ? (wide + ext) : (wide - ext);
    if (wide[33:31] == 3'b000 || wide[33:31] == 3'b111) begin
      offset_sat = wide[31:0];
    end else if (wide[33]) begin
      offset_sat = 32'h8000_0000;
    end else begin
      offset_sat = 32'h7fff_ffff;
    end
  endfunction

  assign accept    = pt.valid && pt.ready;
  assign open_line = pt.data.start_line || !have_prev;
  assign pt.ready  = (state == T_IDLE);

  // class-scaled half width in coordinate units
  assign bw_ext = {{(pwlq_pkg::H_W - 16){1'b0}}, pt.data.base_width};
  always_comb begin
    unique case (pt.data.road_class) inside
      pwlq_pkg::CLASS_HIGHWAY:                         h_next = bw_ext << 4;
      pwlq_pkg::CLASS_BOULEVARD, pwlq_pkg::CLASS_AVENUE: h_next = (bw_ext << 3) + (bw_ext << 2);
      pwlq_pkg::CLASS_STREET:                          h_next = bw_ext << 3;
    endcase
  end

  assign calc_req.start  = go;
  assign calc_req.cur_x  = cur_x;
  assign calc_req.cur_y  = cur_y;
  assign calc_req.prev_x = prev_x;
  assign calc_req.prev_y = prev_y;
  assign calc_req.h      = h;

  pwlq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  pwlq_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (calc_req),
    .rsp     (calc_rsp),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

  // corner per vertex: p0 p1 p2 p0 p2 p3
  always_comb begin
    case (vcnt)
      3'd0:    begin sel_cur = 1'b0; plus = 1'b1; end
      3'd1:    begin sel_cur = 1'b0; plus = 1'b0; end
      3'd2:    begin sel_cur = 1'b1; plus = 1'b0; end
      3'd3:    begin sel_cur = 1'b0; plus = 1'b1; end
      3'd4:    begin sel_cur = 1'b1; plus = 1'b0; end
      3'd5:    begin sel_cur = 1'b1; plus = 1'b1; end
      default: begin sel_cur = 1'b0; plus = 1'b0; end
    endcase
  end

  always_comb begin
    vert_next.vert_x      = offset_sat(sel_cur ? cur_x : prev_x, calc_rsp.mox,
                                       plus ^ calc_rsp.neg_x);
    vert_next.vert_y      = offset_sat(sel_cur ? cur_y : prev_y, calc_rsp.moy,
                                       plus ^ calc_rsp.neg_y);
    vert_next.vert_z      = z;
    vert_next.vert_color  = color;
    vert_next.last_vertex = (vcnt == pwlq_pkg::VTX_LAST);
  end

  // output register loads when empty or being drained
  assign load      = (state == T_EMIT) && (!out_vld || vtx.ready);
  assign vtx.valid = out_vld;
  assign vtx.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      have_prev <= 1'b0;
      go        <= 1'b0;
      out_vld   <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      go <= 1'b0;
      if (load) begin
        out_vld <= 1'b1;
      end else if (vtx.ready) begin
        out_vld <= 1'b0;
      end
      if (load) out_data <= vert_next;

      unique case (state)
        T_IDLE: begin
          if (accept) begin
            if (open_line) begin
              prev_x    <= pt.data.point_x;
              prev_y    <= pt.data.point_y;
              have_prev <= 1'b1;
            end else begin
              cur_x <= pt.data.point_x;
              cur_y <= pt.data.point_y;
              h     <= h_next;
              z     <= pt.data.layer_height;
              color <= pt.data.color_rgba;
              go    <= 1'b1;
              state <= T_CALC;
            end
          end
        end
        T_CALC: begin
          if (calc_rsp.done) begin
            vcnt  <= '0;
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (load) begin
            vcnt <= vcnt + 1'b1;
            if (vcnt == pwlq_pkg::VTX_LAST) begin
              // segment end becomes the next start
              prev_x <= cur_x;
              prev_y <= cur_y;
              state  <= T_IDLE;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // a pending vertex that is not the last one means the segment is still out
  `PWLQ_ASSERT_IMP(a_emit_open, clk, rst, vtx.valid && !vtx.data.last_vertex, state == T_EMIT, "non-last vertex outside emit")
  // the sequencer only finishes for a segment in flight
  `PWLQ_ASSERT_IMP(a_done_calc, clk, rst, calc_rsp.done, state == T_CALC, "offset done while not computing")
  // offsets never exceed the half width
  `PWLQ_ASSERT_IMP(a_off_bound, clk, rst, calc_rsp.done, calc_rsp.mox <= h && calc_rsp.moy <= h, "offset above half width")
  // a closing point starts the computation
  `PWLQ_ASSERT_NXT(a_seg_start, clk, rst, accept && !open_line, state == T_CALC && go, "segment point did not start work")

endmodule
